/* sv/first_fit_block_allocator_top_macros.svh */
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define FFBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define FFBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/ffba_pkg.sv */
`default_nettype none

package ffba_pkg;

    localparam int DEF_MAX_BLOCKS  = 1024;
    localparam int DEF_BLOCK_BYTES = 4096;

    localparam int OP_W       = 2;
    localparam int SIZE_W     = 32;
    localparam int ADDR_W     = 48;
    localparam int TOTAL_W    = 11;
    localparam int USAGE_W    = 23;
    localparam int STATUS_W   = 2;
    localparam int MARK_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 48;

    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 11'd1024;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INFO  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NULL     = 2'd1,
        ST_NO_ROOM  = 2'd2,
        ST_BAD_FREE = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ARENA_BASE   = 1'b0,
        CFG_TOTAL_BLOCKS = 1'b1
    } t_cfg_idx;

    localparam logic [MARK_W-1:0] MARK_FREE  = 2'd0;
    localparam logic [MARK_W-1:0] MARK_USED  = 2'd1;
    localparam logic [MARK_W-1:0] MARK_START = 2'd2;

endpackage

`default_nettype wire

/* sv/ffba_if.sv */
`default_nettype none

interface ffba_req_if;
    import ffba_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [SIZE_W-1:0] size_bytes;
    logic [ADDR_W-1:0] address;

    modport source (output valid, op, size_bytes, address, input ready);
    modport sink   (input valid, op, size_bytes, address, output ready);
endinterface

interface ffba_rsp_if;
    import ffba_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   block_address;
    logic [USAGE_W-1:0]  total_bytes;
    logic [USAGE_W-1:0]  used_bytes;
    logic [USAGE_W-1:0]  free_bytes;

    modport source (output valid, status, block_address, total_bytes, used_bytes, free_bytes,
                    input ready);
    modport sink   (input valid, status, block_address, total_bytes, used_bytes, free_bytes,
                    output ready);
endinterface

interface ffba_cfg_if;
    import ffba_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/ffba_ram.sv */
`default_nettype none

module ffba_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* sv/ffba_mul.sv */
`default_nettype none

module ffba_mul #(
    parameter int A_W         = 11,
    parameter int BLOCK_BYTES = 4096
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_en,
    input  wire logic [A_W-1:0]                          i_a,
    output logic      [A_W+$clog2(BLOCK_BYTES+1)-1:0]    o_p
);

    localparam int P_W = A_W + $clog2(BLOCK_BYTES + 1);

    logic [P_W-1:0] r_p;

    // scale a block count to bytes
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= P_W'(i_a) * P_W'(BLOCK_BYTES);
        end
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

/* sv/first_fit_block_allocator_top.sv */
// Operation: one request at a time; a usage request only scales counts to bytes; allocate
//   scans the mark RAM, then marks the run; free walks the blocks to the address, checks
//   the start mark, then frees the run. The walk of the mark RAM goes at one block per
//   cycle, and the byte-scaling multiplier is shared by the final steps.
// Reset: synchronous, active low; then a clearing pass over every entry of the
//   mark RAM with requests held off; configuration writes are taken throughout.
`default_nettype none
`include "first_fit_block_allocator_top_macros.svh"

module first_fit_block_allocator_top #(
    parameter int MAX_BLOCKS  = ffba_pkg::DEF_MAX_BLOCKS,
    parameter int BLOCK_BYTES = ffba_pkg::DEF_BLOCK_BYTES
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ffba_cfg_if.sink   i_cfg,
    ffba_req_if.sink   i_req,
    ffba_rsp_if.source o_rsp
);
    import ffba_pkg::*;

    localparam int IDX_W    = $clog2(MAX_BLOCKS);
    localparam int CNT_W    = $clog2(MAX_BLOCKS + 1);
    localparam int P_W      = CNT_W + $clog2(BLOCK_BYTES + 1);
    localparam int CMP_W    = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;
    localparam int SZ_CMP_W = (P_W > SIZE_W) ? P_W : SIZE_W;
    localparam int AD_CMP_W = (P_W > ADDR_W) ? P_W : ADDR_W;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BLOCKS - 1);
    localparam logic [P_W-1:0]   BLK_INC  = P_W'(BLOCK_BYTES);
    localparam logic [CMP_W-1:0] MAX_EXT  = CMP_W'(MAX_BLOCKS);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC_SCAN,
        S_ALLOC_MARK,
        S_FREE_FIND,
        S_FREE_START,
        S_FREE_WALK,
        S_MUL_ADDR,
        S_MUL_TOT,
        S_MUL_USED,
        S_RESULT
    } t_state;

    t_state              r_state;
    t_op                 r_op;
    t_status             r_status;
    logic [IDX_W-1:0]    r_idx;
    logic [IDX_W-1:0]    r_first;
    logic [IDX_W-1:0]    r_last;
    logic [P_W-1:0]      r_acc;
    logic [SIZE_W-1:0]   r_size;
    logic [ADDR_W-1:0]   r_diff;
    logic [ADDR_W-1:0]   r_addr;
    logic [CNT_W-1:0]    r_used;
    logic [USAGE_W-1:0]  r_tot_b;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [ADDR_W-1:0]   r_out_addr;
    logic [USAGE_W-1:0]  r_out_tot;
    logic [USAGE_W-1:0]  r_out_used;
    logic [USAGE_W-1:0]  r_out_free;

    logic [ADDR_W-1:0]   r_arena_base;
    logic [TOTAL_W-1:0]  r_total_blocks;

    logic [CMP_W-1:0]    tot_ext;
    logic [CNT_W-1:0]    tot;
    logic                at_end;
    logic [P_W-1:0]      acc_next;
    logic                fit;
    logic                in_block;
    logic [ADDR_W:0]     diff;
    logic [CNT_W-1:0]    used_dec;
    logic [USAGE_W-1:0]  used_b;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [MARK_W-1:0]   ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [MARK_W-1:0]   ram_rdata;

    logic                mul_en;
    logic [CNT_W-1:0]    mul_a;
    logic [P_W-1:0]      mul_p;

    ffba_ram #(
        .WIDTH (MARK_W),
        .DEPTH (MAX_BLOCKS)
    ) u_marks (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ffba_mul #(
        .A_W         (CNT_W),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .o_p   (mul_p)
    );

    assign tot_ext  = CMP_W'(r_total_blocks);
    assign tot      = (tot_ext > MAX_EXT) ? CNT_W'(MAX_EXT) : CNT_W'(tot_ext);
    assign at_end   = (CNT_W'(r_idx) + CNT_W'(1)) == tot;
    assign acc_next = r_acc + BLK_INC;
    assign fit      = (ram_rdata == MARK_FREE)
                      && (SZ_CMP_W'(acc_next) >= SZ_CMP_W'(r_size));
    assign in_block = AD_CMP_W'(r_diff) < AD_CMP_W'(acc_next);
    assign diff     = {1'b0, i_req.address} - {1'b0, r_arena_base};
    assign used_dec = (r_used != '0) ? r_used - CNT_W'(1) : r_used;
    assign used_b   = USAGE_W'(mul_p);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = MARK_FREE;
        ram_raddr = r_idx + IDX_W'(1);
        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
            end
            S_IDLE: begin
                ram_raddr = '0;
            end
            S_ALLOC_MARK: begin
                ram_we    = 1'b1;
                ram_wdata = (r_idx == r_first) ? MARK_START : MARK_USED;
            end
            S_FREE_FIND: begin
                ram_raddr = r_idx;
            end
            S_FREE_START: begin
                ram_we = (ram_rdata == MARK_START);
            end
            S_FREE_WALK: begin
                ram_we = (ram_rdata == MARK_USED);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        mul_en = 1'b0;
        mul_a  = r_used;
        unique case (r_state)
            S_MUL_ADDR: begin
                mul_en = 1'b1;
                mul_a  = CNT_W'(r_first);
            end
            S_MUL_TOT: begin
                mul_en = 1'b1;
                mul_a  = tot;
            end
            S_MUL_USED: begin
                mul_en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arena_base   <= '0;
            r_total_blocks <= TOTAL_RESET;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_ARENA_BASE:   r_arena_base   <= i_cfg.data[ADDR_W-1:0];
                CFG_TOTAL_BLOCKS: r_total_blocks <= i_cfg.data[TOTAL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_rsp.ready && r_state != S_RESULT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_idx == LAST_IDX) begin
                        r_idx   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_op     <= t_op'(i_req.op);
                        r_addr   <= '0;
                        r_idx    <= '0;
                        r_first  <= '0;
                        r_acc    <= '0;
                        r_size   <= i_req.size_bytes;
                        r_diff   <= diff[ADDR_W-1:0];
                        case (t_op'(i_req.op))
                            OP_ALLOC: begin
                                if (i_req.size_bytes == '0) begin
                                    r_status <= ST_NULL;
                                    r_state  <= S_MUL_TOT;
                                end else if (tot == '0) begin
                                    r_status <= ST_NO_ROOM;
                                    r_state  <= S_MUL_TOT;
                                end else begin
                                    r_status <= ST_OK;
                                    r_state  <= S_ALLOC_SCAN;
                                end
                            end
                            OP_FREE: begin
                                if (i_req.address == '0) begin
                                    r_status <= ST_NULL;
                                    r_state  <= S_MUL_TOT;
                                end else if (diff[ADDR_W] || tot == '0) begin
                                    r_status <= ST_BAD_FREE;
                                    r_state  <= S_MUL_TOT;
                                end else begin
                                    r_status <= ST_OK;
                                    r_state  <= S_FREE_FIND;
                                end
                            end
                            default: begin
                                r_status <= ST_OK;
                                r_state  <= S_MUL_TOT;
                            end
                        endcase
                    end
                end
                S_ALLOC_SCAN: begin
                    if (fit) begin
                        r_last  <= r_idx;
                        r_idx   <= r_first;
                        r_state <= S_ALLOC_MARK;
                    end else if (at_end) begin
                        r_status <= ST_NO_ROOM;
                        r_state  <= S_MUL_TOT;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                        if (ram_rdata != MARK_FREE) begin
                            r_acc   <= '0;
                            r_first <= r_idx + IDX_W'(1);
                        end else begin
                            r_acc <= acc_next;
                        end
                    end
                end
                S_ALLOC_MARK: begin
                    r_used <= r_used + CNT_W'(1);
                    if (r_idx == r_last) begin
                        r_state <= S_MUL_ADDR;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                S_FREE_FIND: begin
                    if (in_block) begin
                        r_state <= S_FREE_START;
                    end else if (at_end) begin
                        r_status <= ST_BAD_FREE;
                        r_state  <= S_MUL_TOT;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                        r_acc <= acc_next;
                    end
                end
                S_FREE_START: begin
                    if (ram_rdata != MARK_START) begin
                        r_status <= ST_BAD_FREE;
                        r_state  <= S_MUL_TOT;
                    end else begin
                        r_used <= used_dec;
                        if (at_end) begin
                            r_state <= S_MUL_TOT;
                        end else begin
                            r_idx   <= r_idx + IDX_W'(1);
                            r_state <= S_FREE_WALK;
                        end
                    end
                end
                S_FREE_WALK: begin
                    if (ram_rdata == MARK_USED) begin
                        r_used <= used_dec;
                        if (at_end) begin
                            r_state <= S_MUL_TOT;
                        end else begin
                            r_idx <= r_idx + IDX_W'(1);
                        end
                    end else begin
                        r_state <= S_MUL_TOT;
                    end
                end
                S_MUL_ADDR: begin
                    r_state <= S_MUL_TOT;
                end
                S_MUL_TOT: begin
                    if (r_op == OP_ALLOC && r_status == ST_OK) begin
                        r_addr <= r_arena_base + ADDR_W'(mul_p);
                    end
                    r_state <= S_MUL_USED;
                end
                S_MUL_USED: begin
                    r_tot_b <= USAGE_W'(mul_p);
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_addr   <= r_addr;
                        r_out_tot    <= r_tot_b;
                        r_out_used   <= used_b;
                        r_out_free   <= (r_used <= tot) ? r_tot_b - used_b : '0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.block_address = r_out_addr;
    assign o_rsp.total_bytes   = r_out_tot;
    assign o_rsp.used_bytes    = r_out_used;
    assign o_rsp.free_bytes    = r_out_free;

    `FFBA_ASSERT_NOW(a_walk_in_arena,
        (r_state == S_ALLOC_SCAN || r_state == S_FREE_FIND || r_state == S_FREE_START
         || r_state == S_FREE_WALK), CNT_W'(r_idx) < tot, "walk index beyond total blocks")
    `FFBA_ASSERT_NEXT(a_mark_counts, r_state == S_ALLOC_MARK,
        r_used == $past(r_used) + CNT_W'(1), "marked block not counted as used")
    `FFBA_ASSERT_NEXT(a_result_holds, r_state == S_RESULT && r_out_valid && !o_rsp.ready,
        r_state == S_RESULT && r_out_valid, "result overwrote a pending response")
    `FFBA_ASSERT_NEXT(a_request_starts, i_req.valid && i_req.ready,
        r_state != S_IDLE, "accepted request did not leave idle")

endmodule

`default_nettype wire
